// File: hdl/lrsgd_pkg.sv
// Shared types, constants and command codes for the logistic regression SGD trainer.
// No dependencies; every other file of the block imports this package.
package lrsgd_pkg;

    // Problem size and number formats
    localparam int FEATURE_COUNT    = 6;
    localparam int NUM_W            = FEATURE_COUNT + 1;
    localparam int IDX_W            = $clog2(NUM_W);
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int X_W              = 16;
    localparam int W_W              = 32;
    localparam int P_W              = 16;
    localparam int E_W              = 18;
    localparam int MA_W             = 33;
    localparam int MB_W             = 18;
    localparam int PROD_W           = MA_W + MB_W;
    localparam int ACC_W            = PROD_W;
    localparam int Z_SHIFT          = WEIGHT_FRAC_BITS - 4;
    localparam int Z_W              = ACC_W - Z_SHIFT;
    localparam int T1_SHIFT         = 28 - WEIGHT_FRAC_BITS;
    localparam int T1_W             = X_W + E_W - T1_SHIFT;
    localparam int T2_SHIFT         = 15;
    localparam int D_W              = 35;
    localparam int LO_BITS          = 17;
    localparam int HI_W             = D_W - LO_BITS;
    localparam int STEP_W           = 17;
    localparam int BC_W             = 32;
    localparam int SIB_W            = 6;
    localparam int LEN_W            = 7;
    localparam int SQ_W             = 34;
    localparam int CNT_W            = 6;
    localparam int DIV_STEPS        = BC_W + 1;
    localparam int SQRT_STEPS       = 17;

    // Constants in Q.16, except X_ONE (1.0 in Q3.12) and the batch lengths
    localparam logic [X_W-1:0]    X_ONE        = 16'd4096;
    localparam logic [16:0]       ONE_Q16      = 17'd65536;
    localparam logic [STEP_W-1:0] STEP_RESET   = 17'd65536;
    localparam logic [15:0]       L2_RESET     = 16'd6554;
    localparam logic [LEN_W-1:0]  BLEN_RESET   = 7'd5;
    localparam logic [LEN_W-1:0]  BLEN_MAX     = 7'd64;
    localparam logic [Z_W-1:0]    SIG_SAT      = 39'd327680;
    localparam logic [Z_W-1:0]    SIG_KNEE_HI  = 39'd155648;
    localparam logic [Z_W-1:0]    SIG_KNEE_LO  = 39'd65536;
    localparam logic [16:0]       SIG_OFS_HI   = 17'd55296;
    localparam logic [16:0]       SIG_OFS_MID  = 17'd40960;
    localparam logic [16:0]       SIG_OFS_LO   = 17'd32768;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_L2_RATE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_LENGTH = 1'b1;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_INIT,
        OP_DIV,
        OP_SQRT_INIT,
        OP_SQRT,
        OP_STEP,
        OP_DOT_MUL,
        OP_DOT_ACC,
        OP_SIG,
        OP_T1_MUL,
        OP_T2_MUL,
        OP_DIFF,
        OP_LO_MUL,
        OP_HI_MUL,
        OP_WRITE
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic             finish;
    } cmd_t;

    typedef struct packed {
        logic samples_zero;
        logic out_busy;
    } sts_t;

    typedef struct packed {
        logic signed [X_W-1:0] feature_0;
        logic signed [X_W-1:0] feature_1;
        logic signed [X_W-1:0] feature_2;
        logic signed [X_W-1:0] feature_3;
        logic signed [X_W-1:0] feature_4;
        logic signed [X_W-1:0] feature_5;
        logic                  label;
    } in_t;

    typedef struct packed {
        logic [P_W-1:0]        probability;
        logic signed [W_W-1:0] weight_0;
        logic signed [W_W-1:0] weight_1;
        logic signed [W_W-1:0] weight_2;
        logic signed [W_W-1:0] weight_3;
        logic signed [W_W-1:0] weight_4;
        logic signed [W_W-1:0] weight_5;
        logic signed [W_W-1:0] weight_bias;
    } out_t;

endpackage

// File: hdl/lrsgd_dp.sv
// Datapath of the SGD trainer: weights, shared multiplier, divider, square root, sigmoid.
// Depends on lrsgd_pkg; driven by commands from lrsgd_ctrl.
module lrsgd_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lrsgd_pkg::cmd_t                 cmd,
    output lrsgd_pkg::sts_t                 sts,
    input  lrsgd_pkg::in_t                  in_data,
    input  logic                            cfg_write,
    input  logic [lrsgd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                     cfg_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output lrsgd_pkg::out_t                 out_data
);
    import lrsgd_pkg::*;

    logic signed [W_W-1:0]    w_reg [NUM_W];
    logic signed [X_W-1:0]    x_reg [NUM_W];
    logic                     label_reg;
    logic [BC_W-1:0]          bc_reg;
    logic [SIB_W-1:0]         sib_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [15:0]              l2_reg;
    logic [LEN_W-1:0]         blen_reg;
    logic                     out_valid_reg;
    out_t                     out_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [P_W-1:0]           p_reg;
    logic signed [E_W-1:0]    e_reg;
    logic signed [T1_W-1:0]   t1_reg;
    logic signed [D_W-1:0]    d_reg;
    logic [D_W-1:0]           lo_reg;
    logic [BC_W-1:0]          div_r_reg;
    logic [BC_W:0]            div_sh_reg;
    logic [BC_W:0]            div_q_reg;
    logic [SQ_W-1:0]          sq_rem_reg;
    logic [SQ_W-1:0]          sq_res_reg;
    logic [SQ_W-1:0]          sq_bit_reg;

    logic signed [W_W-1:0]    w_sel;
    logic signed [X_W-1:0]    x_sel;
    logic signed [MA_W-1:0]   ma;
    logic signed [MB_W-1:0]   mb;
    logic signed [PROD_W-1:0] prod_c;
    logic [BC_W:0]            div_rs;
    logic                     div_ge;
    logic [SQ_W-1:0]          sq_trial;
    logic                     sq_ge;
    logic [P_W-1:0]           sig_p;
    logic signed [D_W-1:0]    d_next;
    logic signed [52:0]       full;
    logic signed [36:0]       delta;
    logic signed [37:0]       wsum;
    logic signed [W_W-1:0]    w_new;
    logic [LEN_W-1:0]         len_eff;
    logic [LEN_W-1:0]         sib_inc;

    // Piecewise sigmoid on a Q.16 value, clamped to the 16-bit range
    function automatic logic [P_W-1:0] sigmoid(input logic signed [Z_W-1:0] z);
        logic [Z_W-1:0] a;
        logic [16:0]    y;
        a = z[Z_W-1] ? Z_W'(-z) : Z_W'(z);
        if (a >= SIG_SAT)
            y = ONE_Q16;
        else if (a >= SIG_KNEE_HI)
            y = 17'(a >> 5) + SIG_OFS_HI;
        else if (a >= SIG_KNEE_LO)
            y = 17'(a >> 3) + SIG_OFS_MID;
        else
            y = 17'(a >> 2) + SIG_OFS_LO;
        if (z[Z_W-1])
            y = ONE_Q16 - y;
        if (y[16])
            y = 17'h0FFFF;
        return y[P_W-1:0];
    endfunction

    assign w_sel = w_reg[cmd.idx];
    assign x_sel = x_reg[cmd.idx];

    // Select the shared multiplier operands
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            OP_DOT_MUL:
            begin
                ma = {{(MA_W-W_W){w_sel[W_W-1]}}, w_sel};
                mb = {{(MB_W-X_W){x_sel[X_W-1]}}, x_sel};
            end
            OP_T1_MUL:
            begin
                ma = {{(MA_W-X_W){x_sel[X_W-1]}}, x_sel};
                mb = e_reg;
            end
            OP_T2_MUL:
            begin
                ma = {{(MA_W-W_W){w_sel[W_W-1]}}, w_sel};
                mb = {2'b00, l2_reg};
            end
            OP_LO_MUL:
            begin
                ma = {{(MA_W-LO_BITS){1'b0}}, d_reg[LO_BITS-1:0]};
                mb = {1'b0, step_reg};
            end
            OP_HI_MUL:
            begin
                ma = {{(MA_W-HI_W){d_reg[D_W-1]}}, d_reg[D_W-1:LO_BITS]};
                mb = {1'b0, step_reg};
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod_c = ma * mb;

    // One restoring step of 2^32 / batch count
    assign div_rs = {div_r_reg, div_sh_reg[BC_W]};
    assign div_ge = div_rs >= {1'b0, bc_reg};

    // One restoring square root step
    assign sq_trial = sq_res_reg + sq_bit_reg;
    assign sq_ge    = sq_rem_reg >= sq_trial;

    assign sig_p = sigmoid(acc_reg[ACC_W-1:Z_SHIFT]);

    assign d_next = {{(D_W-T1_W){t1_reg[T1_W-1]}}, t1_reg}
                  - prod_reg[D_W+T2_SHIFT-1:T2_SHIFT];

    // Recombine the split step product and apply it with saturation
    assign full  = {prod_reg[HI_W+MB_W-1:0], {LO_BITS{1'b0}}}
                 + {{(53-D_W){1'b0}}, lo_reg};
    assign delta = full[52:16];
    assign wsum  = {{6{w_sel[W_W-1]}}, w_sel} + {delta[36], delta};
    always_comb
    begin
        if (wsum > 38'sd2147483647)
            w_new = 32'sh7FFFFFFF;
        else if (wsum < -38'sd2147483648)
            w_new = 32'sh80000000;
        else
            w_new = wsum[W_W-1:0];
    end

    // Effective batch length: zero acts as one, capped at 64
    always_comb
    begin
        if (blen_reg == '0)
            len_eff = LEN_W'(1);
        else if (blen_reg > BLEN_MAX)
            len_eff = BLEN_MAX;
        else
            len_eff = blen_reg;
    end
    assign sib_inc = {1'b0, sib_reg} + LEN_W'(1);

    // Hold weights, batch state, configuration and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_W; i++)
                w_reg[i] <= '0;
            bc_reg        <= BC_W'(1);
            sib_reg       <= '0;
            step_reg      <= STEP_RESET;
            l2_reg        <= L2_RESET;
            blen_reg      <= BLEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_L2_RATE:      l2_reg   <= cfg_data;
                    REG_BATCH_LENGTH: blen_reg <= cfg_data[LEN_W-1:0];
                    default:          l2_reg   <= l2_reg;
                endcase
            end
            if (cmd.op == OP_STEP)
                step_reg <= sq_res_reg[STEP_W-1:0];
            if (cmd.op == OP_WRITE)
                w_reg[cmd.idx] <= w_new;
            if (cmd.finish)
            begin
                if (sib_inc >= len_eff)
                begin
                    sib_reg <= '0;
                    if (bc_reg != '1)
                        bc_reg <= bc_reg + BC_W'(1);
                end
                else
                    sib_reg <= sib_inc[SIB_W-1:0];
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Advance the working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                x_reg[0]        <= in_data.feature_0;
                x_reg[1]        <= in_data.feature_1;
                x_reg[2]        <= in_data.feature_2;
                x_reg[3]        <= in_data.feature_3;
                x_reg[4]        <= in_data.feature_4;
                x_reg[5]        <= in_data.feature_5;
                x_reg[NUM_W-1]  <= X_ONE;
                label_reg       <= in_data.label;
                acc_reg         <= '0;
            end
            OP_DIV_INIT:
            begin
                div_r_reg  <= '0;
                div_sh_reg <= {1'b1, {BC_W{1'b0}}};
                div_q_reg  <= '0;
            end
            OP_DIV:
            begin
                div_r_reg  <= div_ge ? BC_W'(div_rs - {1'b0, bc_reg}) : div_rs[BC_W-1:0];
                div_sh_reg <= {div_sh_reg[BC_W-1:0], 1'b0};
                div_q_reg  <= {div_q_reg[BC_W-1:0], div_ge};
            end
            OP_SQRT_INIT:
            begin
                sq_rem_reg <= {1'b0, div_q_reg};
                sq_res_reg <= '0;
                sq_bit_reg <= SQ_W'(1) << 32;
            end
            OP_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_rem_reg <= sq_rem_reg - sq_trial;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_reg <= sq_res_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            OP_DOT_MUL: prod_reg <= prod_c;
            OP_DOT_ACC: acc_reg  <= acc_reg + prod_reg;
            OP_SIG:
            begin
                p_reg <= sig_p;
                e_reg <= label_reg ? E_W'({1'b0, ONE_Q16} - {2'b00, sig_p})
                                   : E_W'(-{2'b00, sig_p});
            end
            OP_T1_MUL: prod_reg <= prod_c;
            OP_T2_MUL:
            begin
                t1_reg   <= prod_reg[T1_W+T1_SHIFT-1:T1_SHIFT];
                prod_reg <= prod_c;
            end
            OP_DIFF:   d_reg    <= d_next;
            OP_LO_MUL: prod_reg <= prod_c;
            OP_HI_MUL:
            begin
                lo_reg   <= prod_reg[D_W-1:0];
                prod_reg <= prod_c;
            end
            default:   acc_reg  <= acc_reg;
        endcase
        if (cmd.finish)
        begin
            out_reg.probability <= p_reg;
            out_reg.weight_0    <= w_reg[0];
            out_reg.weight_1    <= w_reg[1];
            out_reg.weight_2    <= w_reg[2];
            out_reg.weight_3    <= w_reg[3];
            out_reg.weight_4    <= w_reg[4];
            out_reg.weight_5    <= w_reg[5];
            out_reg.weight_bias <= w_reg[NUM_W-1];
        end
    end

    assign sts.samples_zero = (sib_reg == '0);
    assign sts.out_busy     = out_valid_reg && !out_ready;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_reg;

endmodule

// File: hdl/lrsgd_ctrl.sv
// Sequencer of the SGD trainer: steps the datapath through step size, dot product and update.
// Depends on lrsgd_pkg; drives lrsgd_dp through cmd_t and reads sts_t.
module lrsgd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output lrsgd_pkg::cmd_t cmd,
    input  lrsgd_pkg::sts_t sts
);
    import lrsgd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_INIT,
        S_DIV,
        S_SQRT_INIT,
        S_SQRT,
        S_STEP,
        S_DOT_MUL,
        S_DOT_ACC,
        S_SIG,
        S_T1,
        S_T2,
        S_DIFF,
        S_LO,
        S_HI,
        S_WRITE,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Decode the current step into a datapath command and the next step
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        cmd.idx    = cnt_reg[IDX_W-1:0];
        cmd.finish = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    cnt_next   = '0;
                    state_next = sts.samples_zero ? S_DIV_INIT : S_DOT_MUL;
                end
            end
            S_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT_INIT;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            S_SQRT_INIT:
            begin
                cmd.op     = OP_SQRT_INIT;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_STEP;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            S_STEP:
            begin
                cmd.op     = OP_STEP;
                state_next = S_DOT_MUL;
            end
            S_DOT_MUL:
            begin
                cmd.op     = OP_DOT_MUL;
                state_next = S_DOT_ACC;
            end
            S_DOT_ACC:
            begin
                cmd.op = OP_DOT_ACC;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_SIG;
                end
                else
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_DOT_MUL;
                end
            end
            S_SIG:
            begin
                cmd.op     = OP_SIG;
                state_next = S_T1;
            end
            S_T1:
            begin
                cmd.op     = OP_T1_MUL;
                state_next = S_T2;
            end
            S_T2:
            begin
                cmd.op     = OP_T2_MUL;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = S_LO;
            end
            S_LO:
            begin
                cmd.op     = OP_LO_MUL;
                state_next = S_HI;
            end
            S_HI:
            begin
                cmd.op     = OP_HI_MUL;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.op = OP_WRITE;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_FINISH;
                end
                else
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_T1;
                end
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("trainer took a beat but stayed idle");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg < CNT_W'(DIV_STEPS)))
        else $error("divider step count overran");

    a_finish_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && !sts.out_busy) |=> (state_reg == S_IDLE))
        else $error("finish step did not release the sample");

endmodule

// File: hdl/logistic_regression_sgd_trainer.sv
// Top level of the logistic regression SGD trainer.
// Depends on lrsgd_pkg, lrsgd_ctrl and lrsgd_dp.
//
// Usage:
//   in_valid/in_ready/in_data carry one training sample per beat: six Q3.12
//   features and a 0/1 label. out_valid/out_ready/out_data return one beat per
//   sample: the probability taken before the update and all seven updated weights.
//   cfg_write/cfg_index/cfg_data write l2_rate (index 0) or batch_length (index 1);
//   write only while no sample is in flight.
// Sequence:
//   A sample runs from accept to output beat through the dot product on the one
//   shared multiplier, a sigmoid step, the update steps for each weight (gradient
//   and L2 products, difference, low and high step products, write) and a finish
//   step. The first sample of each minibatch first finds the step size: bit-serial
//   division, square root and a load of the result. One sample at a time.
// Reset:
//   Weights clear to zero, batch count to one, step size to 1.0, registers to
//   their defaults. No clearing pass is needed.
// Stall:
//   The result sits in an output register; the next sample is accepted and worked
//   while it waits, and the block holds at its final step until the register frees.
module logistic_regression_sgd_trainer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  lrsgd_pkg::in_t                  in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output lrsgd_pkg::out_t                 out_data,
    input  logic                            cfg_write,
    input  logic [lrsgd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                     cfg_data
);
    import lrsgd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lrsgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    lrsgd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
